// File: rtl/tilt_gated_trial_supervisor_core_assert.svh
// Assertion macros used by the supervisor core RTL.
// Each use names the clock i_clk and the active-low reset i_rst_n of the enclosing module.
`ifndef TILT_GATED_TRIAL_SUPERVISOR_CORE_ASSERT_SVH
`define TILT_GATED_TRIAL_SUPERVISOR_CORE_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define TGTS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the following cycle.
`define TGTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tgts_pkg.sv
// ----------------------------------------------------------------------------
// tgts_pkg
// Types, widths and register codes shared by the trial supervisor modules.
// ----------------------------------------------------------------------------
package tgts_pkg;

    localparam int TRIAL_CNT_W = 20;
    localparam int ANGLE_W     = 16;
    localparam int BAND_W      = 15;
    localparam int HOLD_W      = 16;
    localparam int TTICKS_W    = 20;
    localparam int LOG_W       = 16;
    localparam int MAG_W       = ANGLE_W + 1;
    localparam int TCMP_W      = (TRIAL_CNT_W > TTICKS_W) ? TRIAL_CNT_W : TTICKS_W;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 5;

    localparam logic [BAND_W-1:0]   GATE_BAND_RST  = BAND_W'(500);
    localparam logic [HOLD_W-1:0]   GATE_HOLD_RST  = HOLD_W'(1000);
    localparam logic [TTICKS_W-1:0] TRIAL_RST      = TTICKS_W'(30000);
    localparam logic [BAND_W-1:0]   FALL_LIMIT_RST = BAND_W'(2500);
    localparam logic [LOG_W-1:0]    LOG_PERIOD_RST = LOG_W'(100);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_GATE = 2'd1,
        PH_RUN  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_GATE = 2'd1,
        EV_DONE = 2'd2,
        EV_FALL = 2'd3
    } t_event;

    typedef enum logic {
        FN_TICK  = 1'b0,
        FN_START = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        REG_GATE_BAND  = 3'd0,
        REG_GATE_HOLD  = 3'd1,
        REG_TRIAL      = 3'd2,
        REG_FALL_LIMIT = 3'd3,
        REG_LOG_PERIOD = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [BAND_W-1:0]   gate_band;
        logic [HOLD_W-1:0]   gate_hold_ticks;
        logic [TTICKS_W-1:0] trial_ticks;
        logic [BAND_W-1:0]   fall_limit;
        logic [LOG_W-1:0]    log_period_ticks;
    } t_cfg;

    typedef struct packed {
        t_phase                 phase;
        logic [HOLD_W-1:0]      stable_cnt;
        logic [TRIAL_CNT_W-1:0] trial_cnt;
        logic [LOG_W-1:0]       log_cnt;
    } t_state;

    typedef struct packed {
        t_phase              phase;
        t_event              event_res;
        logic                log_valid;
        logic [ANGLE_W-1:0]  log_angle;
        logic                drive_enable;
    } t_result;

endpackage

// File: rtl/tgts_step.sv
// ----------------------------------------------------------------------------
// tgts_step
// Next-state and result logic for one item of the trial supervisor.
// ----------------------------------------------------------------------------
module tgts_step (
    input  tgts_pkg::t_state                 i_st,
    input  tgts_pkg::t_cfg                   i_cfg,
    input  logic                             i_func,
    input  logic signed [tgts_pkg::ANGLE_W-1:0] i_tilt_angle,
    output tgts_pkg::t_state                 o_st,
    output tgts_pkg::t_result                o_res
);
    import tgts_pkg::*;

    logic signed [MAG_W-1:0] angle_ext;
    logic [MAG_W-1:0]        mag;
    logic [HOLD_W-1:0]       stable_inc;
    logic [TRIAL_CNT_W-1:0]  trial_inc;
    logic [LOG_W-1:0]        log_inc;

    assign angle_ext  = MAG_W'(i_tilt_angle);
    assign mag        = angle_ext[MAG_W-1] ? MAG_W'(-angle_ext) : MAG_W'(angle_ext);
    assign stable_inc = (&i_st.stable_cnt) ? i_st.stable_cnt : i_st.stable_cnt + 1'b1;
    assign trial_inc  = (&i_st.trial_cnt) ? i_st.trial_cnt : i_st.trial_cnt + 1'b1;
    assign log_inc    = (&i_st.log_cnt) ? i_st.log_cnt : i_st.log_cnt + 1'b1;

    always_comb begin
        o_st            = i_st;
        o_res.event_res = EV_NONE;
        o_res.log_valid = 1'b0;
        o_res.log_angle = '0;

        if (i_func == FN_START) begin
            if (i_st.phase == PH_IDLE) begin
                o_st.phase      = PH_GATE;
                o_st.stable_cnt = '0;
            end
        end else begin
            unique case (i_st.phase)
                PH_IDLE: begin
                end
                PH_GATE: begin
                    if (mag < MAG_W'(i_cfg.gate_band)) begin
                        o_st.stable_cnt = stable_inc;
                        if (stable_inc >= i_cfg.gate_hold_ticks) begin
                            o_st.phase      = PH_RUN;
                            o_st.trial_cnt  = '0;
                            o_st.log_cnt    = '0;
                            o_res.event_res = EV_GATE;
                        end
                    end else begin
                        o_st.stable_cnt = '0;
                    end
                end
                PH_RUN: begin
                    o_st.trial_cnt = trial_inc;
                    o_st.log_cnt   = log_inc;
                    // Once the trial length is reached, the angle of this tick is not used.
                    if (TCMP_W'(trial_inc) >= TCMP_W'(i_cfg.trial_ticks)) begin
                        o_st.phase      = PH_IDLE;
                        o_res.event_res = EV_DONE;
                    end else begin
                        if (log_inc >= i_cfg.log_period_ticks) begin
                            o_res.log_valid = 1'b1;
                            o_res.log_angle = i_tilt_angle;
                            o_st.log_cnt    = '0;
                        end
                        if (mag > MAG_W'(i_cfg.fall_limit)) begin
                            o_st.phase      = PH_IDLE;
                            o_res.event_res = EV_FALL;
                        end
                    end
                end
                default: begin
                    o_st.phase = PH_IDLE;
                end
            endcase
        end

        o_res.phase        = o_st.phase;
        o_res.drive_enable = (o_st.phase == PH_RUN);
    end

endmodule

// File: rtl/tilt_gated_trial_supervisor_core.sv
// ----------------------------------------------------------------------------
// tilt_gated_trial_supervisor_core
// Balancing trial supervisor: gating, trial timing, angle logging, fall check.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless its output stalls, and returns
// one result per item in the cycle after its transfer, from an output register.
// The phase and counter registers are updated at the transfer edge by single-level
// compare and increment logic, so the next item may follow in the very next cycle.
// A new item is taken while the output register is empty or its result is being
// taken in the same cycle; a stalled output stops input transfers.
// Registers on the APB port are to be written only while the block is idle.
`include "tilt_gated_trial_supervisor_core_assert.svh"

module tilt_gated_trial_supervisor_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_func,
    input  logic signed [tgts_pkg::ANGLE_W-1:0]  i_tilt_angle,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [1:0]                           o_phase,
    output logic [1:0]                           o_event_res,
    output logic                                 o_log_valid,
    output logic signed [tgts_pkg::ANGLE_W-1:0]  o_log_angle,
    output logic                                 o_drive_enable,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tgts_pkg::ADDR_W-1:0]          paddr,
    input  logic [tgts_pkg::DATA_W-1:0]          pwdata,
    output logic [tgts_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);
    import tgts_pkg::*;

    t_cfg     r_cfg;
    t_state   r_state;
    t_state   n_state;
    t_result  r_res;
    t_result  n_res;
    logic     r_out_valid;
    logic     in_xfer;
    logic     cfg_wr;
    t_reg_idx reg_idx;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign reg_idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gate_band        <= GATE_BAND_RST;
            r_cfg.gate_hold_ticks  <= GATE_HOLD_RST;
            r_cfg.trial_ticks      <= TRIAL_RST;
            r_cfg.fall_limit       <= FALL_LIMIT_RST;
            r_cfg.log_period_ticks <= LOG_PERIOD_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_GATE_BAND:  r_cfg.gate_band        <= pwdata[BAND_W-1:0];
                REG_GATE_HOLD:  r_cfg.gate_hold_ticks  <= pwdata[HOLD_W-1:0];
                REG_TRIAL:      r_cfg.trial_ticks      <= pwdata[TTICKS_W-1:0];
                REG_FALL_LIMIT: r_cfg.fall_limit       <= pwdata[BAND_W-1:0];
                REG_LOG_PERIOD: r_cfg.log_period_ticks <= pwdata[LOG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_GATE_BAND:  prdata = DATA_W'(r_cfg.gate_band);
            REG_GATE_HOLD:  prdata = DATA_W'(r_cfg.gate_hold_ticks);
            REG_TRIAL:      prdata = DATA_W'(r_cfg.trial_ticks);
            REG_FALL_LIMIT: prdata = DATA_W'(r_cfg.fall_limit);
            REG_LOG_PERIOD: prdata = DATA_W'(r_cfg.log_period_ticks);
            default:        prdata = '0;
        endcase
    end

    tgts_step u_step (
        .i_st         (r_state),
        .i_cfg        (r_cfg),
        .i_func       (i_func),
        .i_tilt_angle (i_tilt_angle),
        .o_st         (n_state),
        .o_res        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_IDLE;
            r_state.stable_cnt <= '0;
            r_state.trial_cnt  <= '0;
            r_state.log_cnt    <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state <= n_state;
            end
            if (in_xfer) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is only looked at while valid.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_phase        = r_res.phase;
    assign o_event_res    = r_res.event_res;
    assign o_log_valid    = r_res.log_valid;
    assign o_log_angle    = r_res.log_angle;
    assign o_drive_enable = r_res.drive_enable;

    `TGTS_ASSERT(a_gate_runs, !(r_out_valid && r_res.event_res == EV_GATE) || r_res.phase == PH_RUN, "gate event without running phase")
    `TGTS_ASSERT(a_end_idles, !(r_out_valid && (r_res.event_res == EV_DONE || r_res.event_res == EV_FALL)) || r_res.phase == PH_IDLE, "trial end without idle phase")
    `TGTS_ASSERT(a_log_event, !(r_out_valid && r_res.log_valid) || r_res.event_res == EV_NONE || r_res.event_res == EV_FALL, "log on a gate or done tick")
    `TGTS_ASSERT(a_log_zero, !(r_out_valid && !r_res.log_valid) || r_res.log_angle == '0, "log angle not cleared without log")
    `TGTS_ASSERT_NEXT(a_no_skip_gate, r_state.phase == PH_IDLE, r_state.phase != PH_RUN, "running entered straight from idle")

endmodule
